### design/hbmon_pkg.sv
// ----------------------------------------------------------------------------
// Heartbeat monitor package
// Shared constants, request codes and the token that walks the cell row.
// ----------------------------------------------------------------------------
`default_nettype none

package hbmon_pkg;

   localparam int MAX_CLIENTS_DEFAULT = 16;
   localparam int ID_W                = 32;
   localparam int CTR_W               = 8;
   localparam int SLOT_W              = 6;
   localparam int FAIL_IDX_W          = 4;
   localparam int ENTRY_CNT_W         = 5;

   localparam logic [CTR_W-1:0] MISS_LIMIT_RESET = 8'd10;
   localparam logic [CTR_W-1:0] COUNTER_MAX      = 8'hFF;

   typedef enum logic [1:0] {
      OP_REGISTER  = 2'd0,
      OP_HEARTBEAT = 2'd1,
      OP_TICK      = 2'd2,
      OP_NONE      = 2'd3
   } op_type;

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

   typedef struct packed {
      logic              active;
      op_type            op;
      logic [ID_W-1:0]   id;
      logic              stop;
      logic              fail;
      logic [SLOT_W-1:0] slot;
   } token_type;

endpackage

`default_nettype wire

### design/multi_channel_heartbeat_monitor.sv
// ----------------------------------------------------------------------------
// Multi-channel heartbeat monitor
// Client table with missed-tick counters, checked by a walking token.
// ----------------------------------------------------------------------------
// Once a request is accepted, the accepting edge launches the request token,
// which is then registered in each cell of the row of entry cells in turn,
// and the edge on which it leaves the last cell registers the result. One
// request is in flight at a time; the next one is taken once the result slot
// will be free, at the earliest in the cycle the result is taken.
`default_nettype none

module multi_channel_heartbeat_monitor #(
   parameter int MAX_CLIENTS = hbmon_pkg::MAX_CLIENTS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [1:0]                             req_type,
   input  logic [hbmon_pkg::ID_W-1:0]             req_client_id,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_accepted,
   output logic                                   rsp_all_healthy,
   output logic [hbmon_pkg::FAIL_IDX_W-1:0]       rsp_failing_index,
   output logic [hbmon_pkg::ENTRY_CNT_W-1:0]      rsp_entry_count,
   input  logic                                   csr_we,
   input  logic [hbmon_pkg::CTR_W-1:0]            csr_wdata
);
   import hbmon_pkg::*;

   localparam int CNT_W = $clog2(MAX_CLIENTS + 1);

   state_type        state_ff, state_in;
   token_type        launch_ff, launch_in;
   logic [CNT_W-1:0] used_ff, used_in;
   logic [CTR_W-1:0] limit_ff, limit_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             acc_ff, acc_in;
   logic             healthy_ff, healthy_in;
   logic [FAIL_IDX_W-1:0] fidx_ff, fidx_in;

   token_type        chain [MAX_CLIENTS+1];
   logic [MAX_CLIENTS:0] active_vec;
   token_type        last;
   logic             req_fire;

   assign chain[0] = launch_ff;
   assign last     = chain[MAX_CLIENTS];

   for (genvar g = 0; g < MAX_CLIENTS; g++) begin : g_cell
      hbmon_cell #(.INDEX(g), .CNT_W(CNT_W)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .token_in   (chain[g]),
         .used       (used_ff),
         .miss_limit (limit_ff),
         .token_out  (chain[g+1])
      );
   end

   for (genvar g = 0; g <= MAX_CLIENTS; g++) begin : g_act
      assign active_vec[g] = chain[g].active;
   end

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      state_in         = state_ff;
      launch_in        = launch_ff;
      launch_in.active = 1'b0;
      used_in          = used_ff;
      limit_in         = csr_we ? csr_wdata : limit_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      acc_in           = acc_ff;
      healthy_in       = healthy_ff;
      fidx_in          = fidx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               launch_in.active = 1'b1;
               launch_in.op     = op_type'(req_type);
               launch_in.id     = req_client_id;
               launch_in.stop   = 1'b0;
               launch_in.fail   = 1'b0;
               launch_in.slot   = '0;
               state_in         = ST_WALK;
            end
         end
         ST_WALK: begin
            if (last.active) begin
               rsp_valid_in = 1'b1;
               healthy_in   = (last.op == OP_TICK) && !last.fail;
               fidx_in      = last.fail ? FAIL_IDX_W'(last.slot) : '0;
               case (last.op) inside
                  OP_REGISTER, OP_HEARTBEAT: acc_in = last.stop;
                  OP_TICK:                   acc_in = 1'b1;
                  default:                   acc_in = 1'b0;
               endcase
               if (last.op == OP_REGISTER && last.stop) begin
                  used_in = CNT_W'(used_ff + 1'b1);
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff     <= acc_in;
      healthy_ff <= healthy_in;
      fidx_ff    <= fidx_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         launch_ff    <= '0;
         used_ff      <= '0;
         limit_ff     <= MISS_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launch_ff    <= launch_in;
         used_ff      <= used_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = acc_ff;
   assign rsp_all_healthy   = healthy_ff;
   assign rsp_failing_index = fidx_ff;
   assign rsp_entry_count   = ENTRY_CNT_W'(used_ff);

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_W'(MAX_CLIENTS))
      else $error("entry count above table size");

   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $countones(active_vec) <= 1)
      else $error("more than one token in the cell row");

   a_token_walk: assert property (@(posedge clock) disable iff (reset)
      last.active |-> state_ff == ST_WALK)
      else $error("token left the row outside a walk");

   a_used_grow: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && used_ff != $past(used_ff)) |->
         $past(last.active && last.op == OP_REGISTER && last.stop))
      else $error("entry count changed without a stored register request");

endmodule

`default_nettype wire

### design/hbmon_cell.sv
// ----------------------------------------------------------------------------
// Heartbeat monitor cell
// Holds one table entry and passes the request token on to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module hbmon_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 5
) (
   input  logic                               clock,
   input  logic                               reset,
   input  hbmon_pkg::token_type               token_in,
   input  logic [CNT_W-1:0]                   used,
   input  logic [hbmon_pkg::CTR_W-1:0]        miss_limit,
   output hbmon_pkg::token_type               token_out
);
   import hbmon_pkg::*;

   logic [ID_W-1:0]  id_ff,  id_in;
   logic [CTR_W-1:0] cnt_ff, cnt_in;
   token_type        token_ff, token_in_next;
   logic [CTR_W-1:0] cnt_inc;
   logic             in_range;
   logic             live;

   assign in_range = CNT_W'(INDEX) < used;
   assign live     = token_in.active && !token_in.stop;
   assign cnt_inc  = (cnt_ff == COUNTER_MAX) ? cnt_ff : CTR_W'(cnt_ff + 1'b1);

   always_comb begin
      id_in         = id_ff;
      cnt_in        = cnt_ff;
      token_in_next = token_in;
      if (live) begin
         case (token_in.op)
            OP_REGISTER: begin
               if (CNT_W'(INDEX) == used) begin
                  id_in              = token_in.id;
                  cnt_in             = '0;
                  token_in_next.stop = 1'b1;
               end
            end
            OP_HEARTBEAT: begin
               if (in_range && id_ff == token_in.id) begin
                  cnt_in             = '0;
                  token_in_next.stop = 1'b1;
               end
            end
            OP_TICK: begin
               if (in_range) begin
                  cnt_in = cnt_inc;
                  if (cnt_inc > miss_limit) begin
                     token_in_next.stop = 1'b1;
                     token_in_next.fail = 1'b1;
                     token_in_next.slot = SLOT_W'(INDEX);
                  end
               end
            end
            default: begin
               // no change to the entry; the token passes on
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      id_ff  <= id_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         token_ff <= '0;
      end else begin
         token_ff <= token_in_next;
      end
   end

   assign token_out = token_ff;

endmodule

`default_nettype wire

### tb/tb.sv
// ----------------------------------------------------------------------------
// Heartbeat monitor testbench
// Drives register, heartbeat, check-tick and unused-code requests into the client table
// with random idling on both channels. Every request yields one response,
// which is predicted from a private copy of the table and the miss limit and
// compared field by field. The miss limit is rewritten between phases,
// including its extremes and a long run of ticks that saturates the counters.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   import hbmon_pkg::*;

   localparam int TABLE_DEPTH    = MAX_CLIENTS_DEFAULT;
   localparam int DRAIN_CYCLES   = 2 * (TABLE_DEPTH + 2);
   localparam int LONG_HOLD      = 400;
   localparam int HOLD_AFTER     = 700;
   localparam int WATCHDOG_LIMIT = 3000;

   typedef struct packed {
      logic                   accepted;
      logic                   all_healthy;
      logic [FAIL_IDX_W-1:0]  failing_index;
      logic [ENTRY_CNT_W-1:0] entry_count;
   } verdict_type;

   class client_table_tracker;
      logic [ID_W-1:0]  client_ids[TABLE_DEPTH];
      logic [CTR_W-1:0] miss_counts[TABLE_DEPTH];
      int               used;
      logic [CTR_W-1:0] miss_limit;
      verdict_type      expected_replies[$];
      int               errors;

      function new();
         used       = 0;
         miss_limit = MISS_LIMIT_RESET;
         errors     = 0;
      endfunction

      function void set_limit(logic [CTR_W-1:0] value);
         miss_limit = value;
      endfunction

      function int pending();
         return expected_replies.size();
      endfunction

      function void note_request(op_type op, logic [ID_W-1:0] id);
         verdict_type v;
         v = '0;
         case (op)
            OP_REGISTER: begin
               if (used < TABLE_DEPTH) begin
                  client_ids[used]  = id;
                  miss_counts[used] = '0;
                  used++;
                  v.accepted = 1'b1;
               end
            end
            OP_HEARTBEAT: begin
               for (int i = 0; i < used; i++) begin
                  if (client_ids[i] == id) begin
                     miss_counts[i] = '0;
                     v.accepted = 1'b1;
                     break;
                  end
               end
            end
            OP_TICK: begin
               v.accepted    = 1'b1;
               v.all_healthy = 1'b1;
               for (int i = 0; i < used; i++) begin
                  if (miss_counts[i] != COUNTER_MAX)
                     miss_counts[i]++;
                  if (miss_counts[i] > miss_limit) begin
                     v.all_healthy   = 1'b0;
                     v.failing_index = FAIL_IDX_W'(i);
                     break;
                  end
               end
            end
            default: ;
         endcase
         v.entry_count = ENTRY_CNT_W'(used);
         expected_replies.push_back(v);
      endfunction

      function void check_response(logic acc, logic healthy,
                                   logic [FAIL_IDX_W-1:0] fail_idx,
                                   logic [ENTRY_CNT_W-1:0] count);
         verdict_type v;
         if (expected_replies.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
            return;
         end
         v = expected_replies.pop_front();
         if (v.accepted !== acc) begin
            $error("accepted: expected %0d, got %0d", v.accepted, acc);
            errors++;
         end
         if (v.all_healthy !== healthy) begin
            $error("all_healthy: expected %0d, got %0d", v.all_healthy, healthy);
            errors++;
         end
         if (v.failing_index !== fail_idx) begin
            $error("failing_index: expected %0d, got %0d", v.failing_index, fail_idx);
            errors++;
         end
         if (v.entry_count !== count) begin
            $error("entry_count: expected %0d, got %0d", v.entry_count, count);
            errors++;
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [1:0]             req_type = OP_REGISTER;
   logic [ID_W-1:0]        req_client_id = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_accepted;
   logic                   rsp_all_healthy;
   logic [FAIL_IDX_W-1:0]  rsp_failing_index;
   logic [ENTRY_CNT_W-1:0] rsp_entry_count;
   logic                   csr_we = 1'b0;
   logic [CTR_W-1:0]       csr_wdata = '0;

   client_table_tracker book = new();
   logic [ID_W-1:0]     known_ids[$];
   int                  requests_taken = 0;
   logic                no_idle = 1'b0;

   multi_channel_heartbeat_monitor #(
      .MAX_CLIENTS(TABLE_DEPTH)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_client_id    (req_client_id),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_accepted     (rsp_accepted),
      .rsp_all_healthy  (rsp_all_healthy),
      .rsp_failing_index(rsp_failing_index),
      .rsp_entry_count  (rsp_entry_count),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we)
            book.set_limit(csr_wdata);
         if (req_valid && req_ready) begin
            book.note_request(op_type'(req_type), req_client_id);
            requests_taken++;
         end
         if (rsp_valid && rsp_ready)
            book.check_response(rsp_accepted, rsp_all_healthy,
                                rsp_failing_index, rsp_entry_count);
      end
   end

   function automatic int pick_gap();
      int roll;
      if (no_idle)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      if (roll < 98)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // idle at random, and hold off once for a long stretch so the block backs up
   initial begin : receiver
      int gap;
      bit held;
      held = 1'b0;
      while (reset)
         @(posedge clock);
      forever begin
         @(posedge clock);
         if (!held && requests_taken >= HOLD_AFTER) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            gap = pick_gap();
            if (gap > 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("end of test: mismatches");
      $finish;
   end

   task automatic send_request(input op_type op, input logic [ID_W-1:0] id);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_type      <= op;
      req_client_id <= id;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   task automatic register_client(input logic [ID_W-1:0] id);
      send_request(OP_REGISTER, id);
      if (known_ids.size() < TABLE_DEPTH)
         known_ids.push_back(id);
   endtask

   function automatic logic [ID_W-1:0] known_or_fresh(input int fresh_odds);
      if (known_ids.size() == 0 || $urandom_range(0, fresh_odds - 1) == 0)
         return $urandom;
      return known_ids[$urandom_range(0, known_ids.size() - 1)];
   endfunction

   task automatic send_random_requests(input int count, input int tick_share);
      int roll;
      repeat (count) begin
         roll = $urandom_range(0, 999);
         if (roll < 15)
            register_client(known_or_fresh(1) ^ ($urandom_range(0, 7) == 0 ?
                            '0 : $urandom));
         else if (roll < 45)
            send_request(OP_NONE, $urandom);
         else if (roll < 45 + tick_share)
            send_request(OP_TICK, $urandom);
         else
            send_request(OP_HEARTBEAT, known_or_fresh(10));
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (book.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [CTR_W-1:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // empty table, unknown heartbeat, unused code
      send_request(OP_TICK, $urandom);
      send_request(OP_HEARTBEAT, 32'h0000_0005);
      send_request(OP_NONE, 32'hFFFF_FFFF);
      register_client(32'h0000_0000);
      register_client(32'hFFFF_FFFF);
      register_client(32'hFFFF_FFFF);
      send_request(OP_HEARTBEAT, 32'hFFFF_FFFF);
      // cross the reset limit on the first entry, then on the second
      repeat (11) send_request(OP_TICK, $urandom);
      send_request(OP_HEARTBEAT, 32'h0000_0000);
      send_request(OP_TICK, $urandom);
      send_request(OP_HEARTBEAT, 32'h1234_5678);
      send_request(OP_NONE, 32'h0000_0000);
      wait_idle();

      write_limit(8'd0);
      send_random_requests(150, 300);
      wait_idle();

      write_limit(8'd3);
      send_random_requests(400, 250);
      wait_idle();

      // saturate every counter, then clear a few
      write_limit(8'd255);
      repeat (300) send_request(OP_TICK, $urandom);
      repeat (20) send_request(OP_HEARTBEAT, known_or_fresh(20));
      wait_idle();

      write_limit(8'd254);
      send_random_requests(300, 400);
      wait_idle();

      write_limit(8'd10);
      no_idle <= 1'b1;
      send_random_requests(500, 350);
      wait_idle();

      write_limit(8'd30);
      no_idle <= 1'b0;
      send_random_requests(300, 450);
      wait_idle();

      if (book.errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

`default_nettype wire
